// ===== rtl/qpi_pkg.sv =====
`timescale 1ns / 1ps
package qpi_pkg;

	// World and pool geometry
	localparam int WORLD_LOG2 = 10;
	localparam int MIN_LOG2   = 5;
	localparam int POOL_SLOTS = 4096;

	// Port field widths
	localparam int COORD_W    = 10;
	localparam int SLOT_OUT_W = 12;
	localparam int GROUPS_W   = 3;

	// Internal widths
	localparam int SLOT_W = $clog2(POOL_SLOTS);
	localparam int NF_W   = SLOT_W + 1;
	localparam int BIT_W  = $clog2(WORLD_LOG2);
	localparam int MASK_W = 8;

	// Descent levels: bits WORLD_LOG2-1 down to MIN_LOG2-1
	localparam int NUM_LEVELS = (MIN_LOG2 > WORLD_LOG2) ? 0 : WORLD_LOG2 - MIN_LOG2 + 1;
	localparam int FIRST_BIT  = WORLD_LOG2 - 1;
	localparam int LAST_BIT   = MIN_LOG2 - 1;

	// Mask layout and reset values
	localparam logic [MASK_W-1:0] EXIST_Q0   = 8'h80;
	localparam logic [MASK_W-1:0] LEAF_Q0    = 8'h08;
	localparam logic [MASK_W-1:0] MASK_RESET = 8'h0F;
	localparam int                GROUP_SLOTS = 4;
	localparam logic [NF_W-1:0]   NF_RESET   = NF_W'(5);
	localparam logic [SLOT_W-1:0] ROOT_BASE  = SLOT_W'(1);
	localparam logic [GROUPS_W-1:0] GROUPS_MAX = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_WAIT
	} qpi_state_t;

	// Pick one coordinate bit; bits beyond the port width read as zero
	function automatic logic coord_bit(input logic [COORD_W-1:0] c, input logic [BIT_W-1:0] b);
		logic r;
		r = 1'b0;
		for (int i = 0; i < COORD_W; i++) begin
			if (int'(b) == i) begin
				r = c[i];
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/qpi_point_if.sv =====
`timescale 1ns / 1ps
interface qpi_point_if;
	import qpi_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] point_x;
	logic [COORD_W-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== rtl/qpi_result_if.sv =====
`timescale 1ns / 1ps
interface qpi_result_if;
	import qpi_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [SLOT_OUT_W-1:0] final_slot;
	logic [GROUPS_W-1:0]   groups_claimed;
	logic                  status;

	modport source (output valid, output final_slot, output groups_claimed, output status,
		input ready);
	modport sink   (input valid, input final_slot, input groups_claimed, input status,
		output ready);
endinterface

// ===== rtl/qpi_ram.sv =====
`timescale 1ns / 1ps
module qpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/quadtree_point_insert.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Fields                                  Handshake
// point    in   point_x, point_y                        valid/ready
// result   out  final_slot, groups_claimed, status      valid/ready
//
// One item at a time: the item is accepted in ST_IDLE, then each tree level
// passes ST_READ (mask and child pointer read) and ST_EVAL (evaluate and write
// back) until the last level or a full pool, then ST_WAIT hands the item to the
// output register. After reset a clearing pass over all POOL_SLOTS slots (4096)
// initializes the slot store; no item is accepted until it ends. A stalled
// output holds the next result in the block and keeps point.ready low.
module quadtree_point_insert (
	input  logic                clk,
	input  logic                arst_n,
	qpi_point_if.sink           point,
	qpi_result_if.source        result
);
	import qpi_pkg::*;

	qpi_state_t state_q, state_d;

	logic [SLOT_W-1:0]   clr_q;
	logic [NF_W-1:0]     nf_q;
	logic                pend_q;
	logic                res_valid_q;

	logic [SLOT_W-1:0]   cur_q, par_q, pw_addr_q;
	logic [MASK_W-1:0]   parmask_q, pw_data_q;
	logic [1:0]          psub_q;
	logic                haspar_q;
	logic [BIT_W-1:0]    b_q;
	logic [COORD_W-1:0]  x_q, y_q;
	logic [GROUPS_W-1:0] groups_q;
	logic                status_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	logic [GROUPS_W-1:0] res_groups_q;
	logic                res_status_q;

	logic                mask_we, base_we;
	logic [SLOT_W-1:0]   mask_waddr, base_waddr;
	logic [MASK_W-1:0]   mask_wdata, mask_rdata;
	logic [SLOT_W-1:0]   base_wdata, base_rdata;

	logic                accept, out_free, load_out;
	logic [1:0]          sub;
	logic [MASK_W-1:0]   ex_bit, mask_new;
	logic                exists, full, claim, stop, last;
	logic [NF_W:0]       nf_need;
	logic [SLOT_W:0]     target;
	logic [SLOT_W-1:0]   cur_next;

	qpi_ram #(.WIDTH(MASK_W), .DEPTH(POOL_SLOTS)) u_mask_ram (
		.clk   (clk),
		.we    (mask_we),
		.waddr (mask_waddr),
		.wdata (mask_wdata),
		.raddr (cur_q),
		.rdata (mask_rdata)
	);

	qpi_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (base_waddr),
		.wdata (base_wdata),
		.raddr (cur_q),
		.rdata (base_rdata)
	);

	// Evaluate one level from the read data
	always_comb begin
		sub      = {coord_bit(y_q, b_q), coord_bit(x_q, b_q)};
		ex_bit   = EXIST_Q0 >> sub;
		exists   = |(mask_rdata & ex_bit);
		nf_need  = {1'b0, nf_q} + (NF_W+1)'(GROUP_SLOTS);
		full     = nf_need > (NF_W+1)'(POOL_SLOTS);
		claim    = !exists && !full;
		stop     = !exists && full;
		last     = b_q == BIT_W'(LAST_BIT);
		mask_new = claim ? (mask_rdata | ex_bit) : mask_rdata;
		target   = {1'b0, base_rdata} + (SLOT_W+1)'(sub);
		cur_next = (target < (SLOT_W+1)'(POOL_SLOTS)) ? target[SLOT_W-1:0] : '0;
	end

	assign accept   = point.valid && point.ready;
	assign out_free = !res_valid_q || result.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == SLOT_W'(POOL_SLOTS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (point.valid) begin
					state_d = (NUM_LEVELS == 0) ? ST_WAIT : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = (stop || last) ? ST_WAIT : ST_READ;
			end
			ST_WAIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Outputs and memory write ports
	always_comb begin
		point.ready = 1'b0;
		load_out    = 1'b0;
		mask_we     = 1'b0;
		mask_waddr  = pw_addr_q;
		mask_wdata  = pw_data_q;
		base_we     = 1'b0;
		base_waddr  = target[SLOT_W-1:0];
		base_wdata  = nf_q[SLOT_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mask_we    = 1'b1;
				mask_waddr = clr_q;
				mask_wdata = MASK_RESET;
				base_we    = 1'b1;
				base_waddr = clr_q;
				base_wdata = (clr_q == '0) ? ROOT_BASE : '0;
			end
			ST_IDLE: begin
				point.ready = 1'b1;
			end
			ST_EVAL: begin
				// Set the exists bit and link the new group
				mask_we    = claim;
				mask_waddr = cur_q;
				mask_wdata = mask_new;
				base_we    = claim && (target < (SLOT_W+1)'(POOL_SLOTS));
			end
			ST_READ, ST_WAIT: begin
				// Finish the parent leaf clear left by the previous level
				mask_we  = pend_q;
				load_out = (state_q == ST_WAIT) && out_free;
			end
			default: begin
				point.ready = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			nf_q        <= NF_RESET;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (state_q == ST_EVAL && claim) begin
				nf_q <= nf_q + NF_W'(GROUP_SLOTS);
			end
			pend_q <= (state_q == ST_EVAL) && claim && haspar_q;
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= point.point_x;
			y_q      <= point.point_y;
			cur_q    <= '0;
			haspar_q <= 1'b0;
			b_q      <= BIT_W'(FIRST_BIT);
			groups_q <= '0;
			status_q <= 1'b0;
		end else if (state_q == ST_EVAL) begin
			if (stop) begin
				status_q <= 1'b1;
			end else begin
				cur_q     <= cur_next;
				par_q     <= cur_q;
				parmask_q <= mask_new;
				psub_q    <= sub;
				haspar_q  <= 1'b1;
				b_q       <= b_q - BIT_W'(1);
			end
			if (claim) begin
				pw_addr_q <= par_q;
				pw_data_q <= parmask_q & ~(LEAF_Q0 >> psub_q);
				if (groups_q != GROUPS_MAX) begin
					groups_q <= groups_q + GROUPS_W'(1);
				end
			end
		end
		if (load_out) begin
			res_slot_q   <= SLOT_OUT_W'(cur_q);
			res_groups_q <= groups_q;
			res_status_q <= status_q;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.final_slot     = res_slot_q;
	assign result.groups_claimed = res_groups_q;
	assign result.status         = res_status_q;
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import qpi_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 185;
	localparam int NUM_PHASES    = 4;
	localparam int HISTORY_DEPTH = 256;
	localparam int NUM_ROWS      = 16;

	localparam logic INS_OK        = 1'b0;
	localparam logic INS_POOL_FULL = 1'b1;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] final_slot;
		logic [GROUPS_W-1:0]   groups;
		logic                  status;
	} insert_result_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               typed;
		insert_result_t     want;
	} point_row_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	// Directed points; typed rows carry a result readable off the tree by hand
	localparam point_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{10'd0,    10'd0,    1'b1, '{12'd21, 3'd6, INS_OK}},
		'{10'd0,    10'd0,    1'b1, '{12'd21, 3'd0, INS_OK}},
		'{10'd15,   10'd15,   1'b1, '{12'd21, 3'd0, INS_OK}},
		'{10'd1023, 10'd1023, 1'b1, '{12'd48, 3'd6, INS_OK}},
		'{10'd1008, 10'd1008, 1'b1, '{12'd48, 3'd0, INS_OK}},
		'{10'd1023, 10'd0,    1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd0,    10'd1023, 1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd512,  10'd512,  1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd511,  10'd511,  1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd16,   10'd0,    1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd0,    10'd16,   1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd16,   10'd16,   1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd341,  10'd682,  1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd682,  10'd341,  1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd1023, 10'd1008, 1'b0, '{12'd0,  3'd0, INS_OK}},
		'{10'd32,   10'd48,   1'b0, '{12'd0,  3'd0, INS_OK}}
	};

	logic clk;
	logic arst_n;

	qpi_point_if  pt ();
	qpi_result_if res ();

	quadtree_point_insert uut (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (pt),
		.result (res)
	);

	// Shadow copy of the slot store
	logic [MASK_W-1:0] tree_mask [POOL_SLOTS];
	int unsigned       group_base [POOL_SLOTS];
	int unsigned       free_slot;

	insert_result_t pending_results [$];
	point_t         placed_points [$];

	int src_idle_pct;
	int snk_stall_pct;
	bit hold_arm;
	int hold_left;
	bit hold_started;

	int cycle_count;
	int mismatch_count;
	int items_sent;
	int results_seen;
	int full_count;
	int groups_total;

	// Generate clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Count cycles
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Abort a hung run
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("Timeout after %0d cycles, %0d results pending", cycle_count,
			pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

	function automatic void reset_tree();
		for (int i = 0; i < POOL_SLOTS; i++) begin
			tree_mask[i]  = MASK_RESET;
			group_base[i] = 0;
		end
		group_base[0] = 32'(ROOT_BASE);
		free_slot     = 32'(NF_RESET);
	endfunction

	// Walk the point down the tree, claiming child groups as needed
	function automatic insert_result_t insert_point(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		int unsigned    cur;
		int unsigned    par;
		int unsigned    psub;
		int unsigned    sub;
		int unsigned    child;
		int unsigned    groups;
		bit             have_par;
		bit             full;
		insert_result_t r;
		cur      = 0;
		par      = 0;
		psub     = 0;
		groups   = 0;
		have_par = 1'b0;
		full     = 1'b0;
		for (int b = FIRST_BIT; b >= LAST_BIT && b >= 0; b--) begin
			sub = {30'd0, y[b], x[b]};
			if ((tree_mask[cur] & (EXIST_Q0 >> sub)) == 0) begin
				if (free_slot + GROUP_SLOTS > POOL_SLOTS) begin
					full = 1'b1;
					break;
				end
				child = group_base[cur] + sub;
				if (child < POOL_SLOTS) begin
					group_base[child] = free_slot;
				end
				tree_mask[cur] = tree_mask[cur] | (EXIST_Q0 >> sub);
				if (have_par) begin
					tree_mask[par] = tree_mask[par] & ~(LEAF_Q0 >> psub);
				end
				free_slot = free_slot + GROUP_SLOTS;
				groups++;
			end
			par      = cur;
			psub     = sub;
			have_par = 1'b1;
			cur      = group_base[cur] + sub;
			if (cur >= POOL_SLOTS) begin
				cur = 0;
			end
		end
		r.final_slot = cur[SLOT_OUT_W-1:0];
		r.groups     = (groups > GROUPS_MAX) ? GROUPS_MAX : groups[GROUPS_W-1:0];
		r.status     = full ? INS_POOL_FULL : INS_OK;
		return r;
	endfunction

	// Offer one point, wait for acceptance, then record its expected result
	task automatic offer_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input bit typed, input insert_result_t typed_result);
		int             gap;
		insert_result_t predicted;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct) gap++;
		if (gap > 0) begin
			pt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt.valid   <= 1'b1;
		pt.point_x <= x;
		pt.point_y <= y;
		do @(posedge clk); while (pt.ready !== 1'b1);
		predicted = insert_point(x, y);
		pending_results.push_back(typed ? typed_result : predicted);
		items_sent++;
		groups_total += int'(predicted.groups);
		if (predicted.status == INS_POOL_FULL) begin
			full_count++;
		end
	endtask

	// Lower valid and hold until every result is back
	task automatic drain_results();
		pt.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() > 0);
	endtask

	// Pick a fresh point, a revisit of a placed one, or its near neighbor
	function automatic point_t pick_point();
		point_t p;
		int     roll;
		roll = $urandom_range(99);
		if (placed_points.size() > 0 && roll < 25) begin
			p = placed_points[$urandom_range(placed_points.size() - 1)];
			p.x[3:0] = 4'($urandom_range(15));
			p.y[3:0] = 4'($urandom_range(15));
			if (roll < 10) begin
				p.x[4] = ~p.x[4];
				p.y[5] = 1'($urandom_range(1));
			end
		end else begin
			p.x = COORD_W'($urandom_range(1023));
			p.y = COORD_W'($urandom_range(1023));
			placed_points.push_back(p);
			if (placed_points.size() > HISTORY_DEPTH) begin
				void'(placed_points.pop_front());
			end
		end
		return p;
	endfunction

	// Check results and drive ready
	initial begin
		insert_result_t want;
		res.ready    <= 1'b0;
		hold_left    = 0;
		hold_started = 1'b0;
		forever begin
			@(posedge clk);
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Unexpected result: slot %0d groups %0d status %0d",
							res.final_slot, res.groups_claimed, res.status);
					end
				end else begin
					want = pending_results.pop_front();
					if (res.final_slot !== want.final_slot ||
						res.groups_claimed !== want.groups || res.status !== want.status) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("Mismatch on result %0d: ", results_seen,
								"expected slot %0d groups %0d status %0d, ",
								want.final_slot, want.groups, want.status,
								"got slot %0d groups %0d status %0d",
								res.final_slot, res.groups_claimed, res.status);
						end
					end
				end
			end
			if (hold_arm && !hold_started) begin
				hold_started = 1'b1;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	// Apply reset, run the directed points, then the random phases
	initial begin
		point_t p;
		int     n;
		mismatch_count = 0;
		items_sent     = 0;
		results_seen   = 0;
		full_count     = 0;
		groups_total   = 0;
		src_idle_pct   = 0;
		snk_stall_pct  = 0;
		hold_arm       = 1'b0;
		pt.valid   <= 1'b0;
		pt.point_x <= '0;
		pt.point_y <= '0;
		arst_n = 1'b0;
		reset_tree();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed points, no idling
		for (int i = 0; i < NUM_ROWS; i++) begin
			offer_point(DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].want);
		end
		drain_results();

		// Random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 70;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 70;
				end
				default: begin
					src_idle_pct  = 35;
					snk_stall_pct = 35;
				end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				// Hold the output off for a long stretch while points keep coming
				if (ph == 0 && n == 40) begin
					hold_arm = 1'b1;
				end
				p = pick_point();
				offer_point(p.x, p.y, 1'b0, '0);
				n++;
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatch_count++;
		end
		$display("Inserted %0d points and checked %0d results; %0d groups claimed in all",
			items_sent, results_seen, groups_total);
		$display("Pool ran out on %0d inserts; ", full_count,
			"phases with and without idling, one long output hold");
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
